// ===== rtl/pwct_pkg.sv =====
// Shared types and constants for the page write count threshold block.
package pwct_pkg;

  localparam int ADDR_W    = 48;
  localparam int LEN_W     = 23;
  localparam int THR_W     = 16;
  localparam int SIZE_W    = 8;
  localparam int PIDX_W    = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(194);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGION_ENABLED = 2'd0,
    CFG_REGION_BASE    = 2'd1,
    CFG_REGION_LENGTH  = 2'd2,
    CFG_SYNC_THRESHOLD = 2'd3
  } cfg_reg_t;

  // Region lookup result for one transaction.
  typedef struct packed {
    logic              tracked;
    logic [PIDX_W-1:0] pidx;
  } decode_t;

endpackage

// ===== rtl/pwct_page_decode.sv =====
// Region check and page number extraction for an incoming flush address.
module pwct_page_decode
  import pwct_pkg::*;
#(
  parameter int PAGE_BYTES = 4096,
  parameter int MAX_PAGES  = 1024,
  parameter int AW         = 10
) (
  input  logic              region_enabled,
  input  logic [ADDR_W-1:0] region_base,
  input  logic [LEN_W-1:0]  region_length,
  input  logic [ADDR_W-1:0] access_address,
  output decode_t           dec,
  output logic [AW-1:0]     mem_index
);

  localparam int PB_LOG2 = $clog2(PAGE_BYTES);
  localparam int PAGE_W  = ADDR_W - PB_LOG2;

  logic [ADDR_W:0]   offset;
  logic [PAGE_W-1:0] page;
  logic [PAGE_W-1:0] len_pages;
  logic              tracked;

  // The borrow bit flags an address below the region base.
  assign offset    = {1'b0, access_address} - {1'b0, region_base};
  assign page      = offset[ADDR_W-1:PB_LOG2];
  assign len_pages = PAGE_W'(region_length >> PB_LOG2);

  // Only whole pages that also fit in the counter store are tracked.
  assign tracked = region_enabled && !offset[ADDR_W] &&
                   (page < len_pages) && (page < PAGE_W'(MAX_PAGES));

  assign dec.tracked = tracked;
  assign dec.pidx    = tracked ? page[PIDX_W-1:0] : '0;
  assign mem_index   = page[AW-1:0];

endmodule

// ===== rtl/page_write_count_threshold_core.sv =====
// Top level of the per-page write count tracker with sync threshold.
//
//  port group   direction  handshake          payload
//  cfg          in         cfg_write          cfg_index, cfg_data
//  in           in         in_valid/in_ready  access_address, access_size
//  out          out        out_valid/out_ready in_region, sync_needed, page_index
//
// One transaction per cycle when the output side keeps up; out_valid rises once
// the update stage advances (memory read at the accepting edge, then update).
// A one-entry forward register covers back-to-back hits on the same page.
// After reset, a clearing pass over all MAX_PAGES entries zeroes the counter memory
// and in_ready stays low; configuration writes are taken during it.
// A stalled output holds the update stage, which in turn holds in_ready low.
module page_write_count_threshold_core
  import pwct_pkg::*;
#(
  parameter int PAGE_BYTES = 4096,
  parameter int MAX_PAGES  = 1024,
  parameter int COUNT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ADDR_W-1:0]    access_address,
  input  logic [SIZE_W-1:0]    access_size,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 in_region,
  output logic                 sync_needed,
  output logic [PIDX_W-1:0]    page_index
);

  localparam int AW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CMP_W = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;

  // Configuration registers.
  logic              region_enabled;
  logic [ADDR_W-1:0] region_base;
  logic [LEN_W-1:0]  region_length;
  logic [THR_W-1:0]  sync_threshold;

  // Counter memory and clearing pass.
  logic [COUNT_BITS-1:0] page_mem [MAX_PAGES];
  logic                  clr_active;
  logic [AW-1:0]         clr_addr;

  // Decode of the incoming transaction.
  decode_t       dec;
  logic [AW-1:0] dec_index;

  // Update stage.
  logic                  s1_valid;
  logic                  s1_inside;
  logic [PIDX_W-1:0]     s1_pidx;
  logic [AW-1:0]         s1_maddr;
  logic [SIZE_W-1:0]     s1_size;
  logic [COUNT_BITS-1:0] rd_data;
  logic                  fwd_valid;
  logic [COUNT_BITS-1:0] fwd_val;

  logic                  accept;
  logic                  s1_adv;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS-1:0] sat;
  logic                  hit;
  logic [COUNT_BITS-1:0] new_val;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;

  pwct_page_decode #(
    .PAGE_BYTES(PAGE_BYTES),
    .MAX_PAGES (MAX_PAGES),
    .AW        (AW)
  ) u_decode (
    .region_enabled(region_enabled),
    .region_base   (region_base),
    .region_length (region_length),
    .access_address(access_address),
    .dec           (dec),
    .mem_index     (dec_index)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      region_enabled <= 1'b0;
      region_base    <= '0;
      region_length  <= '0;
      sync_threshold <= THR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_REGION_ENABLED: region_enabled <= cfg_data[0];
        CFG_REGION_BASE:    region_base    <= cfg_data;
        CFG_REGION_LENGTH:  region_length  <= cfg_data[LEN_W-1:0];
        CFG_SYNC_THRESHOLD: sync_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !clr_active && (!s1_valid || s1_adv);
  assign accept   = in_valid && in_ready;

  // The forward register holds the value written at the edge this item was
  // read, which the memory read could not yet see.
  assign cur     = fwd_valid ? fwd_val : rd_data;
  assign sum     = {1'b0, cur} + (COUNT_BITS + 1)'(s1_size);
  assign sat     = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
  assign hit     = CMP_W'(sat) >= CMP_W'(sync_threshold);
  assign new_val = hit ? '0 : sat;

  assign mem_we    = clr_active || (s1_adv && s1_inside);
  assign mem_waddr = clr_active ? clr_addr : s1_maddr;
  assign mem_wdata = clr_active ? '0 : new_val;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      page_mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_data <= page_mem[dec_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == AW'(MAX_PAGES - 1)) begin
        clr_active <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid  <= 1'b1;
        fwd_valid <= s1_adv && s1_inside && (s1_maddr == dec_index);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_inside <= dec.tracked;
      s1_pidx   <= dec.pidx;
      s1_maddr  <= dec_index;
      s1_size   <= access_size;
      fwd_val   <= new_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      in_region   <= s1_inside;
      sync_needed <= s1_inside && hit;
      page_index  <= s1_pidx;
    end
  end

  a_no_accept_while_clearing : assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !in_ready)
    else $error("input accepted during memory clearing pass");

  a_sync_only_in_region : assert property (@(posedge clk) disable iff (rst)
    (out_valid && sync_needed) |-> in_region)
    else $error("sync reported for an address outside the region");

  a_index_zero_outside : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !in_region) |-> (page_index == '0))
    else $error("nonzero page index outside the region");

  a_update_clears_on_sync : assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_inside && hit) |=> (page_mem[$past(s1_maddr)] == '0))
    else $error("counter not cleared after a sync");

endmodule
